[rtl/core/shs_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hash package
// Shared types, constants and the round constant table of the stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

   // Initial hash value, H0 in the top word.
   localparam logic [255:0] INIT_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE      = 8'h80;
   localparam logic [5:0] LEN_START     = 6'd56;
   localparam logic [5:0] LAST_BYTE     = 6'd63;
   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [1:0] LAST_PART     = 2'd3;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ROUND  = 5'b00010,
      ST_ADD    = 5'b00100,
      ST_PAD    = 5'b01000,
      ST_FINISH = 5'b10000
   } shs_state_type;

   // Controls for the round unit and the chaining words.
   typedef struct packed {
      logic       load_work;
      logic       do_round;
      logic       do_add;
      logic       rearm;
      logic [5:0] round_idx;
   } shs_round_ctl_type;

   // Controls for the message schedule window.
   typedef struct packed {
      logic       shift_byte;
      logic       shift_word;
      logic [7:0] byte_val;
   } shs_sched_ctl_type;

   // Round constants.
   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

[rtl/core/shs_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one optional message byte and an end-of-message mark per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface shs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

`default_nettype wire

[rtl/core/shs_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one 64-bit quarter of the digest per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_part;
   logic [1:0]  part_index;
   logic        last_part;

   modport source (output valid, digest_part, part_index, last_part, input ready);
   modport sink   (input valid, digest_part, part_index, last_part, output ready);
endinterface

`default_nettype wire

[rtl/core/shs_sched.sv]
// ----------------------------------------------------------------------------
// Message schedule window
// A 16-word shift window: bytes shift in while a block fills, and during the
// rounds it shifts one word per cycle, appending the expanded schedule word.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_sched
   import shs_pkg::*;
(
   input  wire logic              clock,
   input  wire shs_sched_ctl_type sched_ctl,
   output logic [31:0]            sched_word
);

   logic [511:0] win_ff;
   logic [511:0] win_in;
   logic [31:0]  next_word;
   logic [31:0]  w0, w1, w9, w14;

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // Taps at w[j-16], w[j-15], w[j-7] and w[j-2].
   assign w0  = win_ff[511:480];
   assign w1  = win_ff[479:448];
   assign w9  = win_ff[223:192];
   assign w14 = win_ff[63:32];

   assign next_word  = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
   assign sched_word = w0;

   // Byte fill or word shift.
   always_comb begin
      win_in = win_ff;
      if (sched_ctl.shift_byte) begin
         win_in = {win_ff[503:0], sched_ctl.byte_val};
      end else if (sched_ctl.shift_word) begin
         win_in = {win_ff[479:0], next_word};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

[rtl/core/shs_round.sv]
// ----------------------------------------------------------------------------
// Compression round unit
// Holds the chaining words and the eight working variables, and applies one
// SHA-256 round per cycle, then folds the result into the chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_round
   import shs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire shs_round_ctl_type round_ctl,
   input  wire logic [31:0]       sched_word,
   output logic [255:0]           chain_words
);

   logic [255:0] chain_ff;
   logic [255:0] chain_in;
   logic [255:0] work_ff;
   logic [255:0] work_in;
   logic [255:0] chain_sum;
   logic [31:0]  a, b, c, d, e, f, g, h;
   logic [31:0]  t1, t2;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   assign {a, b, c, d, e, f, g, h} = work_ff;

   // One round of the compression function.
   always_comb begin
      t1 = h + big_sigma1(e) + ((e & f) ^ (~e & g)) + round_const(round_ctl.round_idx)
         + sched_word;
      t2 = big_sigma0(a) + ((a & b) ^ (a & c) ^ (b & c));
      work_in = {t1 + t2, a, b, c, d + t1, e, f, g};
   end

   // Word-wise feed-forward into the chaining words.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chain_sum[32*i +: 32] = chain_ff[32*i +: 32] + work_ff[32*i +: 32];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (round_ctl.rearm) begin
         chain_in = INIT_HASH;
      end else if (round_ctl.do_add) begin
         chain_in = chain_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
      end else begin
         chain_ff <= chain_in;
      end
   end

   // Working variables load from the chaining words at block start.
   always_ff @(posedge clock) begin
      if (round_ctl.load_work) begin
         work_ff <= chain_ff;
      end else if (round_ctl.do_round) begin
         work_ff <= work_in;
      end
   end

   assign chain_words = chain_ff;

endmodule

`default_nettype wire

[rtl/core/shs_ctrl.sv]
// ----------------------------------------------------------------------------
// Hash sequencer
// Accepts request transfers, counts bytes and bits, generates the padding
// and length bytes, and steps the round unit through each block.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_ctrl
   import shs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_has_byte,
   input  wire logic              req_end_of_message,
   output logic                   req_ready,
   input  wire logic              digest_busy,
   output logic                   load_digest,
   output shs_round_ctl_type      round_ctl,
   output shs_sched_ctl_type      sched_ctl
);

   shs_state_type state_ff, state_in;
   logic [5:0]    fill_ff, fill_in;
   logic [63:0]   len_ff, len_in;
   logic [5:0]    round_ff, round_in;
   logic          pend_end_ff, pend_end_in;
   logic          pad_mode_ff, pad_mode_in;
   logic          first_pad_ff, first_pad_in;
   logic          final_blk_ff, final_blk_in;
   logic [7:0]    len_byte;

   // Length byte for positions 56 to 63, most significant first.
   assign len_byte = len_ff[{~fill_ff[2:0], 3'b000} +: 8];

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      pend_end_in  = pend_end_ff;
      pad_mode_in  = pad_mode_ff;
      first_pad_in = first_pad_ff;
      final_blk_in = final_blk_ff;
      req_ready    = 1'b0;
      load_digest  = 1'b0;
      round_ctl    = '0;
      sched_ctl    = '0;
      round_ctl.round_idx = round_ff;
      sched_ctl.byte_val  = req_data_byte;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_has_byte) begin
                  sched_ctl.shift_byte = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + BITS_PER_BYTE;
                  if (fill_ff == LAST_BYTE) begin
                     state_in             = ST_ROUND;
                     round_ctl.load_work  = 1'b1;
                     round_in             = '0;
                     pend_end_in          = req_end_of_message;
                  end else if (req_end_of_message) begin
                     state_in     = ST_PAD;
                     pad_mode_in  = 1'b1;
                     first_pad_in = 1'b1;
                  end
               end else if (req_end_of_message) begin
                  state_in     = ST_PAD;
                  pad_mode_in  = 1'b1;
                  first_pad_in = 1'b1;
               end
            end
         end

         // One round per cycle; the window shifts out w[j].
         ST_ROUND: begin
            round_ctl.do_round   = 1'b1;
            sched_ctl.shift_word = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end

         // Feed-forward, then decide where the message stands.
         ST_ADD: begin
            round_ctl.do_add = 1'b1;
            if (pad_mode_ff) begin
               if (final_blk_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  final_blk_in = 1'b1;
                  state_in     = ST_PAD;
               end
            end else if (pend_end_ff) begin
               state_in     = ST_PAD;
               pad_mode_in  = 1'b1;
               first_pad_in = 1'b1;
               pend_end_in  = 1'b0;
            end else begin
               state_in = ST_IDLE;
            end
         end

         // One padding byte per cycle: the marker, zeros, then the length.
         ST_PAD: begin
            sched_ctl.shift_byte = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (first_pad_ff) begin
               sched_ctl.byte_val = PAD_BYTE;
               first_pad_in = 1'b0;
               final_blk_in = (fill_ff < LEN_START);
            end else if (final_blk_ff && (fill_ff >= LEN_START)) begin
               sched_ctl.byte_val = len_byte;
            end else begin
               sched_ctl.byte_val = 8'h00;
            end
            if (fill_ff == LAST_BYTE) begin
               state_in            = ST_ROUND;
               round_ctl.load_work = 1'b1;
               round_in            = '0;
            end
         end

         // Hand the digest over once the output side is free, then re-arm.
         ST_FINISH: begin
            if (!digest_busy) begin
               load_digest     = 1'b1;
               round_ctl.rearm = 1'b1;
               len_in          = '0;
               pad_mode_in     = 1'b0;
               final_blk_in    = 1'b0;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         len_ff       <= '0;
         round_ff     <= '0;
         pend_end_ff  <= 1'b0;
         pad_mode_ff  <= 1'b0;
         first_pad_ff <= 1'b0;
         final_blk_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         round_ff     <= round_in;
         pend_end_ff  <= pend_end_in;
         pad_mode_ff  <= pad_mode_in;
         first_pad_ff <= first_pad_in;
         final_blk_ff <= final_blk_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/shs_out.sv]
// ----------------------------------------------------------------------------
// Digest output stage
// Holds a finished digest and sends it as four 64-bit parts, most
// significant first, independently of the hashing of the next message.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_out
   import shs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_digest,
   input  wire logic [255:0]      digest_words,
   output logic                   digest_busy,
   shs_rsp_if.source              rsp_chan
);

   logic [255:0] digest_ff, digest_in;
   logic [1:0]   part_ff, part_in;
   logic         busy_ff, busy_in;
   logic         xfer;

   assign xfer = busy_ff && rsp_chan.ready;

   always_comb begin
      digest_in = digest_ff;
      part_in   = part_ff;
      busy_in   = busy_ff;
      if (load_digest) begin
         digest_in = digest_words;
         part_in   = '0;
         busy_in   = 1'b1;
      end else if (xfer) begin
         digest_in = {digest_ff[191:0], 64'h0};
         part_in   = part_ff + 2'd1;
         if (part_ff == LAST_PART) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         part_ff <= part_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      digest_ff <= digest_in;
   end

   assign digest_busy          = busy_ff;
   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.digest_part = digest_ff[255:192];
   assign rsp_chan.part_index  = part_ff;
   assign rsp_chan.last_part   = (part_ff == LAST_PART);

endmodule

`default_nettype wire

[rtl/core/sha256_stream_hash.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Hashes a byte stream and returns the 256-bit digest as four 64-bit parts.
// ----------------------------------------------------------------------------
//
//   Channel    Dir  Per transfer
//   req_chan   in   data_byte[7:0], has_byte, end_of_message
//   rsp_chan   out  digest_part[63:0], part_index[1:0], last_part
//
// Each item is taken while the sequencer is idle; the byte that completes a
// 64-byte block starts 64 rounds of the shared round unit and one
// feed-forward step, and no new item is taken until they are done.
// Closing a message shifts padding bytes one per cycle up to the block end,
// compresses one or two blocks, and then hands over the digest once the
// output stage is free. A second block is needed only when eight or fewer
// byte positions remain.
// Reset is synchronous and loads the initial hash value; no clearing pass.
// A stalled response holds back only the hand-over of the next digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hash
   import shs_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   shs_req_if.sink     req_chan,
   shs_rsp_if.source   rsp_chan
);

   shs_round_ctl_type round_ctl;
   shs_sched_ctl_type sched_ctl;
   logic [31:0]       sched_word;
   logic [255:0]      chain_words;
   logic              digest_busy;
   logic              load_digest;

   // Sequencer.
   shs_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_chan.valid),
      .req_data_byte      (req_chan.data_byte),
      .req_has_byte       (req_chan.has_byte),
      .req_end_of_message (req_chan.end_of_message),
      .req_ready          (req_chan.ready),
      .digest_busy        (digest_busy),
      .load_digest        (load_digest),
      .round_ctl          (round_ctl),
      .sched_ctl          (sched_ctl)
   );

   // Message schedule window.
   shs_sched u_sched (
      .clock      (clock),
      .sched_ctl  (sched_ctl),
      .sched_word (sched_word)
   );

   // Round unit and chaining words.
   shs_round u_round (
      .clock       (clock),
      .reset       (reset),
      .round_ctl   (round_ctl),
      .sched_word  (sched_word),
      .chain_words (chain_words)
   );

   // Digest output stage.
   shs_out u_out (
      .clock        (clock),
      .reset        (reset),
      .load_digest  (load_digest),
      .digest_words (chain_words),
      .digest_busy  (digest_busy),
      .rsp_chan     (rsp_chan)
   );

endmodule

`default_nettype wire

[rtl/core/shs_checker.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hash port checker
// Watches the top-level ports for the ordering of digest parts and the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_has_byte,
   input wire logic        req_end_of_message,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_part_index,
   input wire logic        rsp_last_part
);

   // A waiting part stays offered until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped before transfer");

   // Parts of one digest follow each other without a gap, in order.
   a_part_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_part |=>
         rsp_valid && (rsp_part_index == 2'($past(rsp_part_index) + 2'd1)))
      else $error("digest part out of order");

   // The last mark sits on the fourth part only.
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_part == (rsp_part_index == 2'd3)))
      else $error("last part mark mismatch");

   // An empty item leaves the block ready for the next transfer.
   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_has_byte && !req_end_of_message |=> req_ready)
      else $error("empty item left the block busy");

endmodule

bind sha256_stream_hash shs_checker u_shs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_has_byte       (req_chan.has_byte),
   .req_end_of_message (req_chan.end_of_message),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_part_index     (rsp_chan.part_index),
   .rsp_last_part      (rsp_chan.last_part)
);

`default_nettype wire
